// ===== hw/rtl/lr_pkg.sv =====
package lr_pkg;

   // Coordinate width, used by the payload structs below.
   localparam int COORD_BITS = 16;
   // Error term and increments: twice the largest axis delta plus sign.
   localparam int ERR_BITS   = COORD_BITS + 3;
   // Frame dimension registers.
   localparam int DIM_BITS   = 13;
   localparam int AREA_BITS  = 2 * DIM_BITS;
   // Linear index before truncation: signed y times width, plus x.
   localparam int IDX_BITS   = COORD_BITS + DIM_BITS + 2;
   localparam int INDEX_BITS = 24;

   // Frame size after reset.
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

   // Request codes.
   localparam logic [1:0] REQ_MOVE = 2'd0;
   localparam logic [1:0] REQ_LINE = 2'd1;
   localparam logic [1:0] REQ_STEP = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]                   req_type;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic [INDEX_BITS-1:0]        pixel_index;
      logic                         in_frame;
      logic                         last_pixel;
   } rsp_payload_type;

   // Pixel produced by the walker for one step transfer.
   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         last;
   } walk_pixel_type;

endpackage

// ===== hw/rtl/lr_walker.sv =====
module lr_walker
   import lr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type req,
   output walk_pixel_type  pixel
);

   logic signed [COORD_BITS-1:0] pen_x_ff, pen_x_in;
   logic signed [COORD_BITS-1:0] pen_y_ff, pen_y_in;
   logic signed [COORD_BITS-1:0] walk_x_ff, walk_x_in;
   logic signed [COORD_BITS-1:0] walk_y_ff, walk_y_in;
   logic signed [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic signed [ERR_BITS-1:0]   inc_straight_ff, inc_straight_in;
   logic signed [ERR_BITS-1:0]   inc_diagonal_ff, inc_diagonal_in;
   logic                         x_major_ff, x_major_in;
   logic                         x_negative_ff, x_negative_in;
   logic                         y_negative_ff, y_negative_in;
   logic                         drawing_ff, drawing_in;

   logic signed [COORD_BITS:0]   dx;
   logic signed [COORD_BITS:0]   dy;
   logic [COORD_BITS:0]          adx;
   logic [COORD_BITS:0]          ady;
   logic                         line_x_major;
   logic [ERR_BITS-1:0]          dmaj;
   logic [ERR_BITS-1:0]          dmin;
   logic signed [COORD_BITS-1:0] step_x;
   logic signed [COORD_BITS-1:0] step_y;
   logic signed [COORD_BITS-1:0] next_x;
   logic signed [COORD_BITS-1:0] next_y;
   logic                         error_positive;
   logic                         minor_step;
   logic                         reach_end;

   // Line set-up: the pen-to-target vector, its octant and the increments.
   always_comb begin
      dx  = {req.coord_x[COORD_BITS-1], req.coord_x} - {pen_x_ff[COORD_BITS-1], pen_x_ff};
      dy  = {req.coord_y[COORD_BITS-1], req.coord_y} - {pen_y_ff[COORD_BITS-1], pen_y_ff};
      adx = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
      ady = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
      line_x_major = adx >= ady;
      dmaj = line_x_major ? {2'b00, adx} : {2'b00, ady};
      dmin = line_x_major ? {2'b00, ady} : {2'b00, adx};
   end

   // One step: the major axis always moves, the minor one on a positive error.
   always_comb begin
      step_x = {{(COORD_BITS-1){x_negative_ff}}, 1'b1};
      step_y = {{(COORD_BITS-1){y_negative_ff}}, 1'b1};
      error_positive = !error_ff[ERR_BITS-1] && (error_ff != '0);
      minor_step = error_positive;
      if (x_major_ff) begin
         next_x = walk_x_ff + step_x;
         next_y = minor_step ? walk_y_ff + step_y : walk_y_ff;
         reach_end = next_x == major_end_ff;
      end else begin
         next_y = walk_y_ff + step_y;
         next_x = minor_step ? walk_x_ff + step_x : walk_x_ff;
         reach_end = next_y == major_end_ff;
      end
   end

   // Next state for each request code.
   always_comb begin
      pen_x_in        = pen_x_ff;
      pen_y_in        = pen_y_ff;
      walk_x_in       = walk_x_ff;
      walk_y_in       = walk_y_ff;
      major_end_in    = major_end_ff;
      error_in        = error_ff;
      inc_straight_in = inc_straight_ff;
      inc_diagonal_in = inc_diagonal_ff;
      x_major_in      = x_major_ff;
      x_negative_in   = x_negative_ff;
      y_negative_in   = y_negative_ff;
      drawing_in      = drawing_ff;
      pixel.hit       = 1'b0;
      pixel.x         = next_x;
      pixel.y         = next_y;
      pixel.last      = reach_end;
      if (fire) begin
         case (req.req_type)
            REQ_MOVE: begin
               pen_x_in = req.coord_x;
               pen_y_in = req.coord_y;
            end
            REQ_LINE: begin
               x_negative_in   = dx[COORD_BITS];
               y_negative_in   = dy[COORD_BITS];
               x_major_in      = line_x_major;
               major_end_in    = line_x_major ? req.coord_x : req.coord_y;
               inc_straight_in = $signed(dmin << 1);
               inc_diagonal_in = $signed((dmin - dmaj) << 1);
               error_in        = $signed((dmin << 1) - dmaj);
               walk_x_in       = pen_x_ff;
               walk_y_in       = pen_y_ff;
               drawing_in      = dmaj != '0;
            end
            REQ_STEP: begin
               if (drawing_ff) begin
                  pixel.hit  = 1'b1;
                  walk_x_in  = next_x;
                  walk_y_in  = next_y;
                  error_in   = error_ff + (minor_step ? inc_diagonal_ff : inc_straight_ff);
                  drawing_in = !reach_end;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff        <= '0;
         pen_y_ff        <= '0;
         walk_x_ff       <= '0;
         walk_y_ff       <= '0;
         major_end_ff    <= '0;
         error_ff        <= '0;
         inc_straight_ff <= '0;
         inc_diagonal_ff <= '0;
         x_major_ff      <= 1'b0;
         x_negative_ff   <= 1'b0;
         y_negative_ff   <= 1'b0;
         drawing_ff      <= 1'b0;
      end else begin
         pen_x_ff        <= pen_x_in;
         pen_y_ff        <= pen_y_in;
         walk_x_ff       <= walk_x_in;
         walk_y_ff       <= walk_y_in;
         major_end_ff    <= major_end_in;
         error_ff        <= error_in;
         inc_straight_ff <= inc_straight_in;
         inc_diagonal_ff <= inc_diagonal_in;
         x_major_ff      <= x_major_in;
         x_negative_ff   <= x_negative_in;
         y_negative_ff   <= y_negative_in;
         drawing_ff      <= drawing_in;
      end
   end

endmodule

// ===== hw/rtl/line_rasterizer.sv =====
// Line rasterizer: one request transfer per cycle unless rsp_ready stalls the pipeline, one pixel
// per step request while a line is being drawn. Path: a pixel reaches rsp_valid through the
// input register, the walker into the pixel register and the linear index into the result register.
// Throughput: one request per cycle unless rsp_ready stalls; the walker registers feed their own next state.
// Reset (synchronous): clears the pen, the walker and all valid bits and sets
// the frame to 640 by 480.
module line_rasterizer
   import lr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [DIM_BITS-1:0] csr_wdata
);

   logic [DIM_BITS-1:0]          width_ff;
   logic [DIM_BITS-1:0]          height_ff;
   logic [AREA_BITS-1:0]         area_ff;

   logic                         req_v_ff;
   req_payload_type              req_ff;
   logic                         pix_v_ff;
   logic signed [COORD_BITS-1:0] pix_x_ff;
   logic signed [COORD_BITS-1:0] pix_y_ff;
   logic                         pix_last_ff;
   logic                         rsp_v_ff;
   rsp_payload_type              rsp_ff, rsp_in;

   logic                         out_load;
   logic                         pix_load;
   logic                         req_load;
   walk_pixel_type               walk_pixel;

   logic signed [IDX_BITS-1:0]   row_offset;
   logic signed [IDX_BITS-1:0]   lin_index;
   logic                         in_bounds;

   // A stage takes new data when it is empty or its content moves on.
   assign out_load  = !rsp_v_ff || rsp_ready;
   assign pix_load  = !pix_v_ff || out_load;
   assign req_load  = !req_v_ff || pix_load;
   assign req_ready = req_load;

   // Frame size registers and the frame area derived from them.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         area_ff   <= AREA_BITS'(WIDTH_RESET) * AREA_BITS'(HEIGHT_RESET);
      end else begin
         if (csr_write_en && csr_index == CSR_FRAME_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_write_en && csr_index == CSR_FRAME_HEIGHT) begin
            height_ff <= csr_wdata;
         end
         area_ff <= AREA_BITS'(width_ff) * AREA_BITS'(height_ff);
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
      end else if (req_load) begin
         req_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_valid) begin
         req_ff <= req_payload;
      end
   end

   // Pen and walker state; a request is executed as it leaves the input register.
   lr_walker u_walker (
      .clock (clock),
      .reset (reset),
      .fire  (req_v_ff && pix_load),
      .req   (req_ff),
      .pixel (walk_pixel)
   );

   // Pixel register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_v_ff <= 1'b0;
      end else if (pix_load) begin
         pix_v_ff <= req_v_ff && walk_pixel.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_load) begin
         pix_x_ff    <= walk_pixel.x;
         pix_y_ff    <= walk_pixel.y;
         pix_last_ff <= walk_pixel.last;
      end
   end

   // Linear index and the frame test.
   always_comb begin
      row_offset = $signed(IDX_BITS'(pix_y_ff)) * $signed(IDX_BITS'({1'b0, width_ff}));
      lin_index  = row_offset + IDX_BITS'(pix_x_ff);
      in_bounds  = !lin_index[IDX_BITS-1] &&
                   (lin_index < $signed(IDX_BITS'(area_ff)));
      rsp_in.pixel_x     = pix_x_ff;
      rsp_in.pixel_y     = pix_y_ff;
      rsp_in.pixel_index = in_bounds ? lin_index[INDEX_BITS-1:0] : '0;
      rsp_in.in_frame    = in_bounds;
      rsp_in.last_pixel  = pix_last_ff;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_load) begin
         rsp_v_ff <= pix_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && pix_v_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

endmodule
